@@ hw/rtl/bpd_pkg.sv @@
// Shared types, constants and helpers for the 24-bit BMP pixel stream decoder.
// Used by every module of the block; depends on nothing.
package bpd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W  = 13;
	localparam int CNT_W  = 12;
	localparam int IDX_W  = 24;
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 10;
	localparam int PROD_W = DIM_W + CNT_W;

	localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [1:0] MODE_COLOUR = 2'd0;
	localparam logic [1:0] MODE_GREY   = 2'd1;

	localparam logic [PIX_W-1:0] BW_THRESHOLD = 8'd127;

	// Division of a sum of three bytes by three: (s * 683) >> 11 is exact up to 765.
	localparam int                RECIP_W     = 10;
	localparam logic [RECIP_W-1:0] RECIP3     = 10'd683;
	localparam int                RECIP_SHIFT = 11;
	localparam int                MUL3_W      = SUM_W + RECIP_W;

	typedef enum logic [2:0] {
		PH_BLUE  = 3'b001,
		PH_GREEN = 3'b010,
		PH_RED   = 3'b100
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [CNT_W-1:0]  rows_up;
		logic [DIM_W-1:0]  width;
		logic [CNT_W-1:0]  col;
		logic [PIX_W-1:0]  blue;
		logic [PIX_W-1:0]  green;
		logic [PIX_W-1:0]  red;
	} pix_event_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] level;
		logic             last_pixel;
	} pix_result_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/bpd_byte_tracker.sv @@
// Byte grouping, row padding skip and column/row tracking for the BMP decoder.
// Holds the stream state; depends on bpd_pkg.
module bpd_byte_tracker import bpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [PIX_W-1:0]  data_byte,
	input  logic [DIM_W-1:0]  width_q,
	input  logic [DIM_W-1:0]  height_q,
	output pix_event_t        ev
);

	phase_t           phase_q, phase_n;
	logic [PIX_W-1:0] blue_q, blue_n;
	logic [PIX_W-1:0] green_q, green_n;
	logic [CNT_W-1:0] col_q, col_n;
	logic [CNT_W-1:0] row_q, row_n;
	logic [1:0]       pos_q, pos_n;
	logic             pad_q, pad_n;
	logic             done_q, done_n;

	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [CNT_W-1:0] col;
	logic [DIM_W-1:0] row_inc;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] rows_up;

	assign w       = clamp_dim(width_q, MAX_W_DIM);
	assign h       = clamp_dim(height_q, MAX_H_DIM);
	assign col     = ({1'b0, col_q} < w) ? col_q : CNT_W'(w - DIM_W'(1));
	assign row_inc = {1'b0, row_q} + DIM_W'(1);
	assign col_inc = {1'b0, col} + DIM_W'(1);
	assign rows_up = h - DIM_W'(1) - {1'b0, row_q};

	always_comb begin
		phase_n = phase_q;
		blue_n  = blue_q;
		green_n = green_q;
		col_n   = col_q;
		row_n   = row_q;
		pos_n   = pos_q;
		pad_n   = pad_q;
		done_n  = done_q;
		ev         = '0;
		ev.rows_up = rows_up[CNT_W-1:0];
		ev.width   = w;
		ev.col     = col;
		ev.blue    = blue_q;
		ev.green   = green_q;
		ev.red     = data_byte;
		if (!done_q) begin
			if ({1'b0, row_q} >= h) begin
				done_n = 1'b1;
			end else begin
				pos_n = pos_q + 2'd1;
				if (pad_q) begin
					if (pos_n == 2'd0) begin
						pad_n = 1'b0;
					end
				end else begin
					unique case (phase_q)
						PH_BLUE: begin
							blue_n  = data_byte;
							phase_n = PH_GREEN;
						end
						PH_GREEN: begin
							green_n = data_byte;
							phase_n = PH_RED;
						end
						PH_RED: begin
							phase_n  = PH_BLUE;
							ev.valid = 1'b1;
							if (col_inc >= w) begin
								col_n = '0;
								row_n = row_inc[CNT_W-1:0];
								if (row_inc >= h) begin
									done_n  = 1'b1;
									ev.last = 1'b1;
								end else if (pos_n != 2'd0) begin
									pad_n = 1'b1;
								end
							end else begin
								col_n = col_inc[CNT_W-1:0];
							end
						end
						default: begin
							phase_n = PH_BLUE;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLUE;
			blue_q  <= '0;
			green_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pos_q   <= '0;
			pad_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			blue_q  <= blue_n;
			green_q <= green_n;
			col_q   <= col_n;
			row_q   <= row_n;
			pos_q   <= pos_n;
			pad_q   <= pad_n;
			done_q  <= done_n;
		end
	end

endmodule

@@ hw/rtl/bpd_pixel_calc.sv @@
// Index multiply-add, mean of three and mode selection for one finished pixel.
// Purely combinational; depends on bpd_pkg.
module bpd_pixel_calc import bpd_pkg::*; (
	input  pix_event_t   ev,
	input  logic [1:0]   pixel_mode,
	output pix_result_t  res
);

	logic [PROD_W-1:0]  prod;
	logic [SUM_W-1:0]   sum;
	logic [MUL3_W-1:0]  mul3;
	logic [PIX_W-1:0]   mean;

	assign prod = (PROD_W'(ev.rows_up) * PROD_W'(ev.width)) + PROD_W'(ev.col);
	assign sum  = SUM_W'(ev.blue) + SUM_W'(ev.green) + SUM_W'(ev.red);
	assign mul3 = MUL3_W'(sum) * MUL3_W'(RECIP3);
	assign mean = mul3[RECIP_SHIFT +: PIX_W];

	always_comb begin
		res             = '0;
		res.pixel_index = prod[IDX_W-1:0];
		res.last_pixel  = ev.last;
		case (pixel_mode)
			MODE_COLOUR: begin
				res.red   = ev.red;
				res.green = ev.green;
				res.blue  = ev.blue;
			end
			MODE_GREY: begin
				res.level = mean;
			end
			default: begin
				res.level = (mean > BW_THRESHOLD) ? PIX_W'(1) : '0;
			end
		endcase
	end

endmodule

@@ hw/rtl/bmp24_pixel_stream_decoder.sv @@
// Top level of the 24-bit BMP pixel stream decoder: configuration registers,
// input and result pipeline registers; depends on bpd_pkg, bpd_byte_tracker, bpd_pixel_calc.
//
// The block takes one pixel-data byte per cycle unless a stalled result holds it back, and
// delivers each pixel through an input register and a result register. Padding bytes and
// bytes after the last row give no beat. The user must write width, height and mode only
// while the stream is idle; the block does not enforce it. Only reset starts a new image.
module bmp24_pixel_stream_decoder import bpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      data_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_W-1:0]      pixel_index,
	output logic [PIX_W-1:0]      red,
	output logic [PIX_W-1:0]      green,
	output logic [PIX_W-1:0]      blue,
	output logic [PIX_W-1:0]      level,
	output logic                  last_pixel
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [1:0]       mode_q;

	logic             valid_s1;
	logic [PIX_W-1:0] byte_s1;
	logic             valid_s2;
	pix_result_t      res_s2;

	logic        advance;
	logic        accept;
	logic        fire;
	pix_event_t  ev;
	pix_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			mode_q   <= MODE_COLOUR;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	bpd_byte_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.width_q   (width_q),
		.height_q  (height_q),
		.ev        (ev)
	);

	bpd_pixel_calc u_calc (
		.ev         (ev),
		.pixel_mode (mode_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire && ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ev.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_index = res_s2.pixel_index;
	assign red         = res_s2.red;
	assign green       = res_s2.green;
	assign blue        = res_s2.blue;
	assign level       = res_s2.level;
	assign last_pixel  = res_s2.last_pixel;

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_pixel |=> !out_valid)
		else $error("beat delivered after the last pixel of the image");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte while the result side stalled");

	a_mode_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && level != '0 |-> red == '0 && green == '0 && blue == '0)
		else $error("colour and level fields both set in one beat");

endmodule
